// File: rtl/svm_pkg.sv
// Shared types, opcodes, status codes and a helper function of the stack machine step unit.
package svm_pkg;

    // Fixed widths of the configuration registers.
    localparam int STACK_WORDS_W = 11;
    localparam int HEAP_BYTES_W  = 13;

    // Configuration register reset values.
    localparam int STACK_WORDS_RST = 1024;
    localparam int HEAP_BYTES_RST  = 4096;

    // Configuration register indexes.
    localparam logic [0:0] CFG_STACK_WORDS = 1'd0;
    localparam logic [0:0] CFG_HEAP_BYTES  = 1'd1;

    // Item modes.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_EXEC   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Opcodes.
    localparam logic [7:0] OP_PUSH_HEAP = 8'h01;
    localparam logic [7:0] OP_PUSH_IMM  = 8'h02;
    localparam logic [7:0] OP_POP_HEAP  = 8'h03;
    localparam logic [7:0] OP_POP       = 8'h04;
    localparam logic [7:0] OP_SP_ADD    = 8'h05;
    localparam logic [7:0] OP_SP_SUB    = 8'h06;
    localparam logic [7:0] OP_ADD       = 8'h07;
    localparam logic [7:0] OP_SUB       = 8'h08;
    localparam logic [7:0] OP_MUL       = 8'h09;
    localparam logic [7:0] OP_DIV       = 8'h0A;
    localparam logic [7:0] OP_EXTERN    = 8'h0B;
    localparam logic [7:0] OP_JMP       = 8'h0C;
    localparam logic [7:0] OP_INC       = 8'h0D;
    localparam logic [7:0] OP_DEC       = 8'h0E;
    localparam logic [7:0] OP_JGT       = 8'h0F;
    localparam logic [7:0] OP_JLT       = 8'h10;
    localparam logic [7:0] OP_JEQ       = 8'h11;
    localparam logic [7:0] OP_JGE       = 8'h12;
    localparam logic [7:0] OP_JLE       = 8'h13;
    localparam logic [7:0] OP_CALL      = 8'h14;
    localparam logic [7:0] OP_RET       = 8'h15;
    localparam logic [7:0] OP_AND       = 8'h16;
    localparam logic [7:0] OP_OR        = 8'h17;
    localparam logic [7:0] OP_XOR       = 8'h18;
    localparam logic [7:0] OP_NOT       = 8'h19;
    localparam logic [7:0] OP_EXIT      = 8'hFF;

    // Result status codes.
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_EXIT     = 4'd1;
    localparam logic [3:0] ST_INACTIVE = 4'd2;
    localparam logic [3:0] ST_EXTERN   = 4'd3;
    localparam logic [3:0] ST_DIV_ZERO = 4'd4;
    localparam logic [3:0] ST_OVERFLOW = 4'd5;
    localparam logic [3:0] ST_UNDERFLOW = 4'd6;
    localparam logic [3:0] ST_HEAP_RANGE = 4'd7;
    localparam logic [3:0] ST_BAD_TARGET = 4'd8;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         opcode;
        logic signed [31:0] operand;
        logic [11:0]        load_address;
        logic [7:0]         load_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        next_ip;
        logic [3:0]         status;
        logic [7:0]         extern_number;
        logic signed [31:0] top_value;
    } t_out_item;

    typedef struct packed {
        logic [0:0]  index;
        logic [15:0] value;
    } t_cfg_write;

    // Opcodes followed by a four-byte immediate.
    function automatic logic has_imm(input logic [7:0] op);
        logic r;
        unique case (op)
            OP_PUSH_HEAP, OP_PUSH_IMM, OP_POP_HEAP, OP_SP_ADD, OP_SP_SUB, OP_EXTERN,
            OP_JMP, OP_JGT, OP_JLT, OP_JEQ, OP_JGE, OP_JLE, OP_CALL: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/svm_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
interface svm_chan_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/svm_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating and wrapping.
module svm_div
    import svm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quot
);

    localparam int STEPS = 32;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [32:0]      r_rem;
    logic [31:0]      r_q;
    logic [31:0]      r_d;
    logic             r_neg;

    logic [32:0] w_sh;
    logic        w_bit;
    logic [32:0] w_rem;

    always_comb begin
        w_sh  = {r_rem[31:0], r_q[31]};
        w_bit = (w_sh >= {1'b0, r_d});
        w_rem = w_bit ? (w_sh - {1'b0, r_d}) : w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_d   <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_q   <= {r_q[30:0], w_bit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_neg ? (32'd0 - r_q) : r_q;

endmodule

// File: rtl/stack_vm_instruction_step_unit.sv
// Top level of the stack machine step unit: sequencer, divider, stack and heap memories.
//
//   Channel  Dir  Payload        Beat meaning
//   i_in     in   t_in_item      one load, start or instruction step
//   o_out    out  t_out_item     the result of that step
//   i_cfg    in   t_cfg_write    one write to stack_words or heap_bytes
//
// A step takes one beat at a time. A simple step passes DEC, TOP0 and TOP1; stack
// reads add SR0 to SR2, heap words are read in HRD and written in HWR a byte at a
// time, as the single-port-per-direction heap byte memory requires, and a divide
// waits in DIVW on the bit-serial divider. Reset is synchronous and active low; the
// memories have no reset and need no clearing. A stalled result holds the sequencer.
module stack_vm_instruction_step_unit
    import svm_pkg::*;
#(
    parameter int STACK_DEPTH    = 1024,
    parameter int HEAP_DEPTH     = 4096,
    parameter int CODE_ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svm_chan_if.sink    i_in,
    svm_chan_if.source  o_out,
    svm_chan_if.sink    i_cfg
);

    localparam int SIB = $clog2(STACK_DEPTH);
    localparam int HAW = $clog2(HEAP_DEPTH);
    localparam int CAB = CODE_ADDR_BITS;
    localparam int RST_SW = (STACK_WORDS_RST < STACK_DEPTH) ? STACK_WORDS_RST : STACK_DEPTH;
    localparam logic [SIB-1:0] RST_E = SIB'(RST_SW - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_SR0  = 4'd2;
    localparam logic [3:0] S_SR1  = 4'd3;
    localparam logic [3:0] S_SR2  = 4'd4;
    localparam logic [3:0] S_HRD  = 4'd5;
    localparam logic [3:0] S_EXE  = 4'd6;
    localparam logic [3:0] S_DIVW = 4'd7;
    localparam logic [3:0] S_HWR  = 4'd8;
    localparam logic [3:0] S_TOP0 = 4'd9;
    localparam logic [3:0] S_TOP1 = 4'd10;

    // Control state.
    logic [3:0]               r_state, n_state;
    logic [CAB-1:0]           r_ip, n_ip;
    logic [SIB-1:0]           r_sidx, n_sidx;
    logic                     r_run, n_run;
    logic [STACK_WORDS_W-1:0] r_sw;
    logic [HEAP_BYTES_W-1:0]  r_hb;
    logic [2:0]               r_cnt, n_cnt;
    logic                     r_ov, n_ov;

    // Payload registers.
    t_in_item       r_item, n_item;
    logic [31:0]    r_a, n_a;
    logic [31:0]    r_b, n_b;
    logic [31:0]    r_hw, n_hw;
    logic [31:0]    r_wval, n_wval;
    logic [HAW-1:0] r_hbase, n_hbase;
    logic [3:0]     r_status, n_status;
    logic [7:0]     r_ext, n_ext;
    t_out_item      r_out, n_out;

    // Memories and their ports.
    logic [31:0]    r_stack_mem [STACK_DEPTH];
    logic [7:0]     r_heap_mem [HEAP_DEPTH];
    logic [31:0]    r_stk_q;
    logic [7:0]     r_heap_q;
    logic           w_s_we;
    logic [SIB-1:0] w_s_wa;
    logic [31:0]    w_s_wd;
    logic [SIB-1:0] w_s_ra;
    logic           w_h_we;
    logic [HAW-1:0] w_h_wa;
    logic [7:0]     w_h_wd;
    logic [HAW-1:0] w_h_ra;

    // Divider hookup.
    logic        w_div_start;
    logic        w_div_busy;
    logic        w_div_done;
    logic [31:0] w_div_quot;

    // Decode helpers.
    logic [SIB-1:0] w_e;
    logic [31:0]    w_hb;
    logic [31:0]    w_s32;
    logic [31:0]    w_e32;
    logic           w_s_lt_e;
    logic           w_s1_lt_e;
    logic           w_s_zero;
    logic           w_heap_ok;
    logic [33:0]    w_v34;
    logic [33:0]    w_ns;
    logic           w_ns_neg;
    logic           w_ns_hi;
    logic [CAB-1:0] w_nip;
    logic           w_bad_imm;
    logic           w_take;
    logic [31:0]    w_alu;
    logic [3:0]     w_err0;
    logic [SIB-1:0] w_sm1;
    logic [SIB-1:0] w_sp1;
    logic [SIB-1:0] w_sp2;

    // A code target is bad when negative or beyond the code address space.
    function automatic logic bad_target(input logic [31:0] t);
        return t[31] || ((t >> CODE_ADDR_BITS) != 32'd0);
    endfunction

    svm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // The stack memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            r_stack_mem[w_s_wa] <= w_s_wd;
        end
        r_stk_q <= r_stack_mem[w_s_ra];
    end

    // The heap byte memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_h_we) begin
            r_heap_mem[w_h_wa] <= w_h_wd;
        end
        r_heap_q <= r_heap_mem[w_h_ra];
    end

    // Effective limits: the registers are clamped to the supported range.
    always_comb begin
        logic [31:0] sw32;
        logic [31:0] hb32;
        sw32 = 32'(r_sw);
        if (sw32 < 32'd2) begin
            sw32 = 32'd2;
        end else if (sw32 > 32'(STACK_DEPTH)) begin
            sw32 = 32'(STACK_DEPTH);
        end
        hb32 = 32'(r_hb);
        if (hb32 < 32'd4) begin
            hb32 = 32'd4;
        end else if (hb32 > 32'(HEAP_DEPTH)) begin
            hb32 = 32'(HEAP_DEPTH);
        end
        w_e  = SIB'(sw32 - 32'd1);
        w_hb = hb32;
    end

    // Checks that do not need memory data.
    always_comb begin
        w_s32     = 32'(r_sidx);
        w_e32     = 32'(w_e);
        w_s_lt_e  = (w_s32 < w_e32);
        w_s1_lt_e = ((w_s32 + 32'd1) < w_e32);
        w_s_zero  = (r_sidx == '0);
        w_sm1     = r_sidx - SIB'(1);
        w_sp1     = SIB'(w_s32 + 32'd1);
        w_sp2     = SIB'(w_s32 + 32'd2);
        w_heap_ok = !r_item.operand[31] &&
                    (({1'b0, r_item.operand} + 33'd4) <= {1'b0, w_hb});
        w_v34     = {{2{r_item.operand[31]}}, r_item.operand};
        w_ns      = (r_item.opcode == OP_SP_ADD) ? ({2'b00, w_s32} + w_v34)
                                                 : ({2'b00, w_s32} - w_v34);
        w_ns_neg  = w_ns[33];
        w_ns_hi   = !w_ns[33] && (w_ns > {2'b00, w_e32});
        w_nip     = r_ip + (has_imm(r_item.opcode) ? CAB'(5) : CAB'(1));
        w_bad_imm = bad_target(r_item.operand);

        w_err0 = ST_OK;
        unique case (r_item.opcode)
            OP_PUSH_HEAP: begin
                if (!w_heap_ok) w_err0 = ST_HEAP_RANGE;
                else if (w_s_zero) w_err0 = ST_OVERFLOW;
            end
            OP_PUSH_IMM: begin
                if (w_s_zero) w_err0 = ST_OVERFLOW;
            end
            OP_POP_HEAP: begin
                if (!w_heap_ok) w_err0 = ST_HEAP_RANGE;
                else if (!w_s_lt_e) w_err0 = ST_UNDERFLOW;
            end
            OP_POP, OP_INC, OP_DEC, OP_NOT, OP_RET: begin
                if (!w_s_lt_e) w_err0 = ST_UNDERFLOW;
            end
            OP_SP_ADD, OP_SP_SUB: begin
                if (w_ns_neg) w_err0 = ST_OVERFLOW;
                else if (w_ns_hi) w_err0 = ST_UNDERFLOW;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR,
            OP_JGT, OP_JLT, OP_JEQ, OP_JGE, OP_JLE: begin
                if (!w_s1_lt_e) w_err0 = ST_UNDERFLOW;
            end
            OP_JMP: begin
                if (w_bad_imm) w_err0 = ST_BAD_TARGET;
            end
            OP_CALL: begin
                if (w_bad_imm) w_err0 = ST_BAD_TARGET;
                else if (w_s_zero) w_err0 = ST_OVERFLOW;
            end
            default: w_err0 = ST_OK;
        endcase
    end

    // Operations on the two stack items; r_a is the lower item and r_b the top.
    always_comb begin
        w_take = 1'b0;
        unique case (r_item.opcode)
            OP_JGT:  w_take = $signed(r_a) >  $signed(r_b);
            OP_JLT:  w_take = $signed(r_a) <  $signed(r_b);
            OP_JEQ:  w_take = (r_a == r_b);
            OP_JGE:  w_take = $signed(r_a) >= $signed(r_b);
            OP_JLE:  w_take = $signed(r_a) <= $signed(r_b);
            default: w_take = 1'b0;
        endcase

        w_alu = r_a ^ r_b;
        unique case (r_item.opcode)
            OP_ADD:  w_alu = r_a + r_b;
            OP_SUB:  w_alu = r_a - r_b;
            OP_MUL:  w_alu = r_a * r_b;
            OP_AND:  w_alu = r_a & r_b;
            OP_OR:   w_alu = r_a | r_b;
            default: w_alu = r_a ^ r_b;
        endcase
    end

    // The step sequencer. Every state that finishes a step commits ip and the stack
    // index and moves on to the top-of-stack read, which always follows the last
    // memory write, so the read never overlaps a pending write.
    always_comb begin
        n_state  = r_state;
        n_ip     = r_ip;
        n_sidx   = r_sidx;
        n_run    = r_run;
        n_cnt    = r_cnt;
        n_ov     = r_ov && !o_out.ready;
        n_item   = r_item;
        n_a      = r_a;
        n_b      = r_b;
        n_hw     = r_hw;
        n_wval   = r_wval;
        n_hbase  = r_hbase;
        n_status = r_status;
        n_ext    = r_ext;
        n_out    = r_out;

        w_s_we      = 1'b0;
        w_s_wa      = r_sidx;
        w_s_wd      = r_item.operand;
        w_s_ra      = r_sidx;
        w_h_we      = 1'b0;
        w_h_wa      = r_hbase + HAW'(r_cnt[1:0]);
        w_h_wd      = r_wval[7:0];
        w_h_ra      = r_hbase + HAW'(r_cnt[1:0]);
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_item   = i_in.data;
                    n_status = ST_OK;
                    n_ext    = 8'd0;
                    n_state  = S_DEC;
                end
            end

            S_DEC: begin
                n_state = S_TOP0;
                priority if (r_item.mode == MODE_LOAD) begin
                    if (32'(r_item.load_address) < w_hb) begin
                        w_h_we = 1'b1;
                        w_h_wa = HAW'(r_item.load_address);
                        w_h_wd = r_item.load_byte;
                    end else begin
                        n_status = ST_HEAP_RANGE;
                    end
                end else if (r_item.mode == MODE_START) begin
                    // Start also seeds heap word 0 with the empty stack index.
                    n_ip    = '0;
                    n_sidx  = w_e;
                    n_run   = 1'b1;
                    n_wval  = 32'(w_e);
                    n_hbase = '0;
                    n_cnt   = 3'd0;
                    n_state = S_HWR;
                end else if (r_item.mode == MODE_EXEC && r_run) begin
                    if (w_err0 != ST_OK) begin
                        n_status = w_err0;
                        n_run    = 1'b0;
                    end else begin
                        unique case (r_item.opcode)
                            OP_PUSH_HEAP: begin
                                n_hbase = HAW'(r_item.operand);
                                n_cnt   = 3'd0;
                                n_state = S_HRD;
                            end
                            OP_SP_ADD, OP_SP_SUB: begin
                                n_hbase = '0;
                                n_cnt   = 3'd0;
                                n_state = S_HRD;
                            end
                            OP_PUSH_IMM: begin
                                w_s_we = 1'b1;
                                w_s_wa = w_sm1;
                                w_s_wd = r_item.operand;
                                n_sidx = w_sm1;
                                n_ip   = w_nip;
                            end
                            OP_CALL: begin
                                w_s_we = 1'b1;
                                w_s_wa = w_sm1;
                                w_s_wd = 32'(w_nip);
                                n_sidx = w_sm1;
                                n_ip   = CAB'(r_item.operand);
                            end
                            OP_POP: begin
                                n_sidx = w_sp1;
                                n_ip   = w_nip;
                            end
                            OP_EXTERN: begin
                                n_status = ST_EXTERN;
                                n_ext    = r_item.operand[7:0];
                                n_ip     = w_nip;
                            end
                            OP_JMP: begin
                                n_ip = CAB'(r_item.operand);
                            end
                            OP_EXIT: begin
                                n_status = ST_EXIT;
                                n_run    = 1'b0;
                                n_ip     = w_nip;
                            end
                            OP_POP_HEAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR,
                            OP_XOR, OP_INC, OP_DEC, OP_NOT, OP_RET,
                            OP_JGT, OP_JLT, OP_JEQ, OP_JGE, OP_JLE: begin
                                n_state = S_SR0;
                            end
                            default: begin
                                n_ip = w_nip;
                            end
                        endcase
                    end
                end else begin
                    // Unused mode, or an instruction while halted.
                    n_status = r_run ? ST_OK : ST_INACTIVE;
                end
            end

            S_SR0: begin
                n_state = S_SR1;
            end

            S_SR1: begin
                n_b = r_stk_q;
                unique case (r_item.opcode)
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR,
                    OP_JGT, OP_JLT, OP_JEQ, OP_JGE, OP_JLE: begin
                        w_s_ra  = w_sp1;
                        n_state = S_SR2;
                    end
                    default: n_state = S_EXE;
                endcase
            end

            S_SR2: begin
                n_a     = r_stk_q;
                n_state = S_EXE;
            end

            S_HRD: begin
                // Each byte arrives in the cycle after its address; shift in low byte first.
                if (r_cnt != 3'd0) begin
                    n_hw = {r_heap_q, r_hw[31:8]};
                end
                if (r_cnt == 3'd4) begin
                    n_state = S_EXE;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end

            S_EXE: begin
                n_state = S_TOP0;
                unique case (r_item.opcode)
                    OP_PUSH_HEAP: begin
                        w_s_we = 1'b1;
                        w_s_wa = w_sm1;
                        w_s_wd = r_hw;
                        n_sidx = w_sm1;
                        n_ip   = w_nip;
                    end
                    OP_SP_ADD, OP_SP_SUB: begin
                        n_wval  = (r_item.opcode == OP_SP_ADD) ? (r_hw + r_item.operand)
                                                               : (r_hw - r_item.operand);
                        n_hbase = '0;
                        n_cnt   = 3'd0;
                        n_sidx  = SIB'(w_ns);
                        n_ip    = w_nip;
                        n_state = S_HWR;
                    end
                    OP_POP_HEAP: begin
                        n_wval  = r_b;
                        n_hbase = HAW'(r_item.operand);
                        n_cnt   = 3'd0;
                        n_sidx  = w_sp1;
                        n_ip    = w_nip;
                        n_state = S_HWR;
                    end
                    OP_DIV: begin
                        if (r_b == 32'd0) begin
                            n_status = ST_DIV_ZERO;
                            n_run    = 1'b0;
                        end else begin
                            w_div_start = 1'b1;
                            n_state     = S_DIVW;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR: begin
                        w_s_we = 1'b1;
                        w_s_wa = w_sp1;
                        w_s_wd = w_alu;
                        n_sidx = w_sp1;
                        n_ip   = w_nip;
                    end
                    OP_INC, OP_DEC, OP_NOT: begin
                        w_s_we = 1'b1;
                        w_s_wa = r_sidx;
                        if (r_item.opcode == OP_INC) begin
                            w_s_wd = r_b + 32'd1;
                        end else if (r_item.opcode == OP_DEC) begin
                            w_s_wd = r_b - 32'd1;
                        end else begin
                            w_s_wd = ~r_b;
                        end
                        n_ip = w_nip;
                    end
                    OP_JGT, OP_JLT, OP_JEQ, OP_JGE, OP_JLE: begin
                        if (w_take && w_bad_imm) begin
                            n_status = ST_BAD_TARGET;
                            n_run    = 1'b0;
                        end else begin
                            n_sidx = w_sp2;
                            n_ip   = w_take ? CAB'(r_item.operand) : w_nip;
                        end
                    end
                    OP_RET: begin
                        if (bad_target(r_b)) begin
                            n_status = ST_BAD_TARGET;
                            n_run    = 1'b0;
                        end else begin
                            n_ip   = CAB'(r_b);
                            n_sidx = w_sp1;
                        end
                    end
                    default: begin
                        n_ip = w_nip;
                    end
                endcase
            end

            S_DIVW: begin
                if (w_div_done) begin
                    w_s_we  = 1'b1;
                    w_s_wa  = w_sp1;
                    w_s_wd  = w_div_quot;
                    n_sidx  = w_sp1;
                    n_ip    = w_nip;
                    n_state = S_TOP0;
                end
            end

            S_HWR: begin
                w_h_we = 1'b1;
                n_wval = r_wval >> 8;
                if (r_cnt == 3'd3) begin
                    n_state = S_TOP0;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end

            S_TOP0: begin
                n_state = S_TOP1;
            end

            S_TOP1: begin
                // The read address stays on the stack index, so a stall keeps the data.
                if (!r_ov || o_out.ready) begin
                    n_ov                = 1'b1;
                    n_out.next_ip       = 16'(r_ip);
                    n_out.status        = r_status;
                    n_out.extern_number = r_ext;
                    n_out.top_value     = w_s_lt_e ? r_stk_q : 32'd0;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ip    <= '0;
            r_sidx  <= RST_E;
            r_run   <= 1'b0;
            r_cnt   <= 3'd0;
            r_ov    <= 1'b0;
            r_sw    <= STACK_WORDS_W'(STACK_WORDS_RST);
            r_hb    <= HEAP_BYTES_W'(HEAP_BYTES_RST);
        end else begin
            r_state <= n_state;
            r_ip    <= n_ip;
            r_sidx  <= n_sidx;
            r_run   <= n_run;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            if (i_cfg.valid) begin
                if (i_cfg.data.index == CFG_STACK_WORDS) begin
                    r_sw <= i_cfg.data.value[STACK_WORDS_W-1:0];
                end else begin
                    r_hb <= i_cfg.data.value[HEAP_BYTES_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_a      <= n_a;
        r_b      <= n_b;
        r_hw     <= n_hw;
        r_wval   <= n_wval;
        r_hbase  <= n_hbase;
        r_status <= n_status;
        r_ext    <= n_ext;
        r_out    <= n_out;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // The divider only runs while the sequencer waits for it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == S_DIVW))
        else $error("divider busy outside its wait state");

    // A fault on an executed instruction always halts the machine.
    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TOP1 && r_item.mode == MODE_EXEC && r_status >= ST_DIV_ZERO)
        |-> !r_run)
        else $error("fault status reported while still running");

    // A result beat is only raised from the result state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == S_TOP1))
        else $error("result raised outside the result state");

endmodule

// File: tb/stack_vm_instruction_step_unit_tb.sv
// Self-checking testbench of the stack machine step unit, with a scoreboard class.
`timescale 1ns / 1ps
module stack_vm_instruction_step_unit_tb;
    import svm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_MAX = 1024;
    localparam int HEAP_MAX  = 4096;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    // The scoreboard mirrors the machine state. A step can be evaluated without
    // committing it, which lets the stimulus side reject items that would read a
    // stack or heap entry that was never written.
    class vm_scoreboard;
        logic [10:0] stack_words_reg;
        logic [12:0] heap_bytes_reg;
        logic [15:0] ip;
        int          sidx;
        logic        running;
        logic [31:0] stk_mem [STACK_MAX];
        bit          stk_known [STACK_MAX];
        logic [7:0]  heap_mem [HEAP_MAX];
        bit          heap_known [HEAP_MAX];
        t_out_item   pending [$];
        int          errors;

        function new();
            stack_words_reg = 11'(STACK_WORDS_RST);
            heap_bytes_reg  = 13'(HEAP_BYTES_RST);
            ip      = '0;
            running = 1'b0;
            errors  = 0;
            sidx    = stack_limit() - 1;
            foreach (stk_known[i]) stk_known[i] = 1'b0;
            foreach (heap_known[i]) heap_known[i] = 1'b0;
        endfunction

        function int stack_limit();
            int s;
            s = stack_words_reg;
            if (s < 2) s = 2;
            if (s > STACK_MAX) s = STACK_MAX;
            return s;
        endfunction

        function int heap_limit();
            int h;
            h = heap_bytes_reg;
            if (h < 4) h = 4;
            if (h > HEAP_MAX) h = HEAP_MAX;
            return h;
        endfunction

        function void set_cfg(t_cfg_write w);
            if (w.index == CFG_STACK_WORDS) stack_words_reg = w.value[10:0];
            else heap_bytes_reg = w.value[12:0];
        endfunction

        function logic [31:0] stk_get(int i, inout bit unsafe);
            if (!stk_known[i]) unsafe = 1'b1;
            return stk_mem[i];
        endfunction

        function logic [31:0] heap_word(int a, inout bit unsafe);
            for (int k = 0; k < 4; k++) if (!heap_known[a + k]) unsafe = 1'b1;
            return {heap_mem[a + 3], heap_mem[a + 2], heap_mem[a + 1], heap_mem[a]};
        endfunction

        function void heap_put(int a, logic [31:0] v);
            for (int k = 0; k < 4; k++) begin
                heap_mem[a + k]   = v[8*k +: 8];
                heap_known[a + k] = 1'b1;
            end
        endfunction

        function bit takes_imm(logic [7:0] op);
            case (op)
                OP_PUSH_HEAP, OP_PUSH_IMM, OP_POP_HEAP, OP_SP_ADD, OP_SP_SUB, OP_EXTERN,
                OP_JMP, OP_JGT, OP_JLT, OP_JEQ, OP_JGE, OP_JLE, OP_CALL: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function bit bad_target(longint t);
            return t < 0 || t > 65535;
        endfunction

        // Evaluates one step. With commit clear nothing changes; unsafe reports a
        // read of an unwritten entry, the top-of-stack output included.
        function void step(t_in_item it, bit commit, output t_out_item r, output bit unsafe);
            int          top_lim, hb, s, depth, ni, w_idx, a;
            logic [15:0] nip, new_ip;
            logic [3:0]  err;
            logic [31:0] u, w_val, x, y, res;
            longint      v, ns, q;
            logic        new_run, take, in_heap;

            top_lim = stack_limit() - 1;
            hb      = heap_limit();
            r       = '0;
            unsafe  = 1'b0;
            ni      = sidx;
            new_ip  = ip;
            new_run = running;
            w_idx   = -1;
            w_val   = '0;
            u       = it.operand;
            v       = longint'(it.operand);
            r.status = ST_OK;

            if (it.mode == MODE_LOAD) begin
                a = it.load_address;
                if (a < hb) begin
                    if (commit) begin
                        heap_mem[a]   = it.load_byte;
                        heap_known[a] = 1'b1;
                    end
                end else begin
                    r.status = ST_HEAP_RANGE;
                end
            end else if (it.mode == MODE_START) begin
                new_ip  = '0;
                ni      = top_lim;
                new_run = 1'b1;
                if (commit) heap_put(0, 32'(top_lim));
            end else if (it.mode == MODE_UNUSED) begin
                r.status = running ? ST_OK : ST_INACTIVE;
            end else if (!running) begin
                r.status = ST_INACTIVE;
            end else begin
                s       = sidx;
                depth   = (s <= top_lim) ? top_lim - s : 0;
                nip     = ip + (takes_imm(it.opcode) ? 16'd5 : 16'd1);
                err     = ST_OK;
                in_heap = v >= 0 && v + 4 <= hb;
                case (it.opcode)
                    OP_PUSH_HEAP, OP_PUSH_IMM: begin
                        if (it.opcode == OP_PUSH_HEAP && !in_heap) err = ST_HEAP_RANGE;
                        else if (s == 0) err = ST_OVERFLOW;
                        else begin
                            ni    = s - 1;
                            w_idx = s - 1;
                            w_val = (it.opcode == OP_PUSH_IMM) ? u : heap_word(int'(v), unsafe);
                        end
                    end
                    OP_POP_HEAP: begin
                        if (!in_heap) err = ST_HEAP_RANGE;
                        else if (depth < 1) err = ST_UNDERFLOW;
                        else begin
                            x = stk_get(s, unsafe);
                            if (commit) heap_put(int'(v), x);
                            ni = s + 1;
                        end
                    end
                    OP_POP: begin
                        if (depth < 1) err = ST_UNDERFLOW;
                        else ni = s + 1;
                    end
                    OP_SP_ADD, OP_SP_SUB: begin
                        ns = (it.opcode == OP_SP_ADD) ? s + v : s - v;
                        if (ns < 0) err = ST_OVERFLOW;
                        else if (ns > top_lim) err = ST_UNDERFLOW;
                        else begin
                            ni = int'(ns);
                            x  = heap_word(0, unsafe);
                            if (commit) heap_put(0, (it.opcode == OP_SP_ADD) ? x + u : x - u);
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR: begin
                        if (depth < 2) err = ST_UNDERFLOW;
                        else begin
                            y = stk_get(s, unsafe);
                            x = stk_get(s + 1, unsafe);
                            if (it.opcode == OP_DIV && y == 0) err = ST_DIV_ZERO;
                            else begin
                                case (it.opcode)
                                    OP_ADD: res = x + y;
                                    OP_SUB: res = x - y;
                                    OP_MUL: res = x * y;
                                    OP_DIV: begin
                                        // Done in 64 bits so that the most negative
                                        // value divided by minus one wraps cleanly.
                                        q   = longint'($signed(x)) / longint'($signed(y));
                                        res = q[31:0];
                                    end
                                    OP_AND: res = x & y;
                                    OP_OR:  res = x | y;
                                    default: res = x ^ y;
                                endcase
                                w_idx = s + 1;
                                w_val = res;
                                ni    = s + 1;
                            end
                        end
                    end
                    OP_EXTERN: begin
                        r.status        = ST_EXTERN;
                        r.extern_number = u[7:0];
                    end
                    OP_JMP: begin
                        if (bad_target(v)) err = ST_BAD_TARGET;
                        else nip = u[15:0];
                    end
                    OP_INC, OP_DEC, OP_NOT: begin
                        if (depth < 1) err = ST_UNDERFLOW;
                        else begin
                            x     = stk_get(s, unsafe);
                            w_idx = s;
                            w_val = (it.opcode == OP_INC) ? x + 1 :
                                    (it.opcode == OP_DEC) ? x - 1 : ~x;
                        end
                    end
                    OP_JGT, OP_JLT, OP_JEQ, OP_JGE, OP_JLE: begin
                        if (depth < 2) err = ST_UNDERFLOW;
                        else begin
                            y = stk_get(s, unsafe);
                            x = stk_get(s + 1, unsafe);
                            case (it.opcode)
                                OP_JGT: take = $signed(x) >  $signed(y);
                                OP_JLT: take = $signed(x) <  $signed(y);
                                OP_JEQ: take = x == y;
                                OP_JGE: take = $signed(x) >= $signed(y);
                                default: take = $signed(x) <= $signed(y);
                            endcase
                            if (take && bad_target(v)) err = ST_BAD_TARGET;
                            else begin
                                if (take) nip = u[15:0];
                                ni = s + 2;
                            end
                        end
                    end
                    OP_CALL: begin
                        if (bad_target(v)) err = ST_BAD_TARGET;
                        else if (s == 0) err = ST_OVERFLOW;
                        else begin
                            ni    = s - 1;
                            w_idx = s - 1;
                            w_val = {16'd0, nip};
                            nip   = u[15:0];
                        end
                    end
                    OP_RET: begin
                        if (depth < 1) err = ST_UNDERFLOW;
                        else begin
                            x = stk_get(s, unsafe);
                            if (bad_target(longint'($signed(x)))) err = ST_BAD_TARGET;
                            else begin
                                nip = x[15:0];
                                ni  = s + 1;
                            end
                        end
                    end
                    OP_EXIT: begin
                        r.status = ST_EXIT;
                        new_run  = 1'b0;
                    end
                    default: ;
                endcase
                if (err != ST_OK) begin
                    // A fault leaves the stack, heap and ip as they were.
                    r.status = err;
                    new_run  = 1'b0;
                    ni       = sidx;
                    w_idx    = -1;
                end else begin
                    new_ip = nip;
                end
            end

            if (ni < top_lim) begin
                if (ni == w_idx) r.top_value = w_val;
                else r.top_value = stk_get(ni, unsafe);
            end
            r.next_ip = new_ip;

            if (commit) begin
                ip      = new_ip;
                sidx    = ni;
                running = new_run;
                if (w_idx >= 0) begin
                    stk_mem[w_idx]   = w_val;
                    stk_known[w_idx] = 1'b1;
                end
            end
        endfunction

        function void note_item(t_in_item it);
            t_out_item r;
            bit        unused;
            step(it, 1'b1, r, unused);
            pending.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: result beat with nothing expected: %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.next_ip !== want.next_ip) begin
                $display("%0t: next_ip expected %0d got %0d", $time, want.next_ip, got.next_ip);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.extern_number !== want.extern_number) begin
                $display("%0t: extern_number expected %0d got %0d", $time,
                         want.extern_number, got.extern_number);
                errors++;
            end
            if (got.top_value !== want.top_value) begin
                $display("%0t: top_value expected %h got %h", $time,
                         want.top_value, got.top_value);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    svm_chan_if #(.t_payload(t_in_item))   in_ch ();
    svm_chan_if #(.t_payload(t_out_item))  out_ch ();
    svm_chan_if #(.t_payload(t_cfg_write)) cfg_ch ();

    stack_vm_instruction_step_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    vm_scoreboard sb = new();

    // Idle and stall rates in percent, changed per phase by the stimulus process.
    int gap_pct   = 0;
    int stall_pct = 0;
    // A request for one long receiver hold-off; the receiver counts it down itself.
    bit hold_req  = 1'b0;
    int hold_left = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver: ready changes on the falling edge only.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result monitor: one beat per rising edge with valid and ready high.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end

    // The run is capped far beyond the slowest legal completion.
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic t_in_item make_beat(logic [1:0] m, logic [7:0] op, logic [31:0] imm,
                                           logic [11:0] addr, logic [7:0] data);
        t_in_item it;
        it.mode         = m;
        it.opcode       = op;
        it.operand      = imm;
        it.load_address = addr;
        it.load_byte    = data;
        return it;
    endfunction

    // Operand chosen to hit the interesting ranges of each opcode.
    function automatic logic [31:0] pick_operand(logic [7:0] op);
        int hb;
        int sel;
        hb  = sb.heap_limit();
        sel = $urandom_range(99);
        case (op)
            OP_PUSH_HEAP, OP_POP_HEAP: begin
                if (sel < 85) return $urandom_range(0, (hb - 4 < 60) ? hb - 4 : 60);
                if (sel < 90) return hb - 3;
                if (sel < 95) return 32'hFFFF_FFFF;
                return $urandom();
            end
            OP_PUSH_IMM: begin
                if (sel < 40) return $urandom();
                if (sel < 75) return 32'($urandom_range(0, 8) - 4);
                if (sel < 82) return WORD_MIN;
                if (sel < 89) return 32'h7FFF_FFFF;
                if (sel < 95) return 32'd0;
                return 32'hFFFF_FFFF;
            end
            OP_SP_ADD, OP_SP_SUB: begin
                if (sel < 85) return 32'($urandom_range(0, 4) - 2);
                return $urandom();
            end
            OP_JMP, OP_JGT, OP_JLT, OP_JEQ, OP_JGE, OP_JLE, OP_CALL: begin
                if (sel < 80) return $urandom_range(0, 300);
                if (sel < 88) return 32'h0000_FFFF;
                if (sel < 94) return 32'h0001_0000 | $urandom();
                return WORD_MIN | $urandom();
            end
            default: return $urandom();
        endcase
    endfunction

    // One candidate beat, mostly well-formed program steps.
    function automatic t_in_item random_beat();
        logic [7:0] ops [26] = '{OP_PUSH_HEAP, OP_PUSH_IMM, OP_POP_HEAP, OP_POP, OP_SP_ADD,
                                 OP_SP_SUB, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EXTERN, OP_JMP,
                                 OP_INC, OP_DEC, OP_JGT, OP_JLT, OP_JEQ, OP_JGE, OP_JLE,
                                 OP_CALL, OP_RET, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_EXIT};
        t_in_item   it;
        int         sel;
        logic [7:0] op;
        sel = $urandom_range(99);
        it  = make_beat(MODE_EXEC, $urandom(), $urandom(), $urandom(), $urandom());
        if (!sb.running) begin
            if (sel < 60) it.mode = MODE_START;
            else if (sel < 85) it.mode = MODE_LOAD;
            else if (sel < 92) it.mode = MODE_UNUSED;
        end else begin
            if (sel < 8) it.mode = MODE_LOAD;
            else if (sel < 10) it.mode = MODE_START;
            else if (sel < 12) it.mode = MODE_UNUSED;
        end
        if (it.mode == MODE_LOAD && $urandom_range(99) < 80)
            it.load_address = $urandom_range(0, sb.heap_limit() - 1);
        if (it.mode == MODE_EXEC) begin
            // Exits are kept rare so that programs run long enough to get deep.
            op = ops[$urandom_range(0, 25)];
            if (op == OP_EXIT && $urandom_range(3) != 0) op = OP_PUSH_IMM;
            if ($urandom_range(99) < 5) op = $urandom();
            it.opcode  = op;
            it.operand = pick_operand(op);
        end
        return it;
    endfunction

    // Offers one beat; a beat that would read unwritten storage is swapped for a start.
    task automatic send_beat(t_in_item it);
        t_out_item dummy;
        bit        unsafe;
        sb.step(it, 1'b0, dummy, unsafe);
        if (unsafe) it = make_beat(MODE_START, $urandom(), $urandom(), $urandom(), $urandom());
        if ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        t_in_item it;
        t_out_item dummy;
        bit unsafe;
        for (int n = 0; n < count; n++) begin
            // Retry a few candidates before falling back to a start.
            for (int k = 0; k < 8; k++) begin
                it = random_beat();
                sb.step(it, 1'b0, dummy, unsafe);
                if (!unsafe) break;
            end
            send_beat(it);
        end
    endtask

    // Waits for every expected result, then lets the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        t_cfg_write w;
        w.index = idx;
        w.value = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_cfg(w);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int stack_set [5] = '{1024, 2, 2047, 0, 0};
        int heap_set  [5] = '{4096, 4, 8191, 0, 0};
        int gaps      [5] = '{0, 55, 0, 22, 0};
        int stalls    [5] = '{0, 0, 55, 22, 0};
        int hb;

        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats: inactive machine, divide corner cases, the underflow, heap range
        // and bad target faults, extern, unknown opcode, the unused mode and exit.
        send_beat(make_beat(MODE_EXEC, OP_PUSH_IMM, 32'd1, 12'd0, 8'd0));
        send_beat(make_beat(MODE_UNUSED, OP_NOT, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_LOAD, OP_EXIT, 32'd0, 12'd4, 8'h00));
        send_beat(make_beat(MODE_LOAD, OP_EXIT, 32'd0, 12'd5, 8'h00));
        send_beat(make_beat(MODE_LOAD, OP_EXIT, 32'd0, 12'd6, 8'h00));
        send_beat(make_beat(MODE_LOAD, OP_EXIT, 32'd0, 12'd7, 8'h80));
        send_beat(make_beat(MODE_LOAD, OP_EXIT, 32'hFFFF_FFFF, 12'hFFF, 8'hFF));
        send_beat(make_beat(MODE_START, OP_EXIT, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, OP_PUSH_HEAP, 32'd4, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, OP_PUSH_IMM, 32'hFFFF_FFFF, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, OP_DIV, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, OP_PUSH_IMM, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, OP_DIV, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_START, OP_EXIT, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, OP_POP, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_START, OP_EXIT, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, OP_PUSH_HEAP, 32'd4093, 12'd0, 8'd0));
        send_beat(make_beat(MODE_START, OP_EXIT, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, OP_JMP, 32'hFFFF_FFFF, 12'd0, 8'd0));
        send_beat(make_beat(MODE_START, OP_EXIT, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, OP_EXTERN, 32'h1234_56AB, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, 8'h20, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_UNUSED, OP_EXIT, 32'd0, 12'd0, 8'd0));
        send_beat(make_beat(MODE_EXEC, OP_EXIT, 32'd0, 12'd0, 8'd0));

        // Random phases, each under a new register setting and idle pattern.
        for (int p = 0; p < 5; p++) begin
            drain();
            if (p == 4) begin
                stack_set[p] = $urandom_range(2, 40);
                heap_set[p]  = $urandom_range(4, 300);
            end
            write_reg(CFG_STACK_WORDS, 16'(stack_set[p]));
            write_reg(CFG_HEAP_BYTES, 16'(heap_set[p]));
            gap_pct   = gaps[p];
            stall_pct = stalls[p];
            // Fill the low heap so that word reads there are defined.
            hb = sb.heap_limit();
            for (int a = 0; a < 64 && a < hb; a++)
                send_beat(make_beat(MODE_LOAD, $urandom(), $urandom(), 12'(a), $urandom()));
            send_beat(make_beat(MODE_START, $urandom(), $urandom(), $urandom(), $urandom()));
            send_random(80);
            if (p == 0) hold_req = 1'b1;
            if (p == 3) begin
                in_ch.valid <= 1'b0;
                while (sb.pending.size() != 0) @(negedge i_clk);
            end
            send_random(80);
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
